### rtl/rwhf_pkg.sv
// Package for the ring write head finder.
// Holds widths, register indexes, reset values and the result struct.
// No dependencies.
package rwhf_pkg;

   localparam int STAMP_W = 32;
   localparam int DELTA_W = 32;
   localparam int LENGTH_W = 14;
   localparam int INDEX_W = 13;
   localparam int COUNT_W = 14;
   localparam int OUT_SLOTS = 4;

   localparam int MAX_RING_DEFAULT = 8192;
   localparam int LOG_SLOTS_DEFAULT = 4;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_DELTA = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_LENGTH = 1'd1;

   localparam logic [DELTA_W-1:0] DELTA_RESET = 32'd10000;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 14'd2048;
   localparam int MIN_RING = 2;

   typedef logic [INDEX_W-1:0] index_type;

   typedef struct packed {
      logic head_found;
      index_type head_index;
      logic [COUNT_W-1:0] break_count;
      index_type [OUT_SLOTS-1:0] break_index;
   } result_type;

endpackage

### rtl/rwhf_gap_check.sv
// Gap classifier: flags a break when later minus earlier is not within
// one tick of the expected delta (wrapping 32-bit arithmetic).
// Depends on rwhf_pkg.
module rwhf_gap_check (
   input  logic [rwhf_pkg::STAMP_W-1:0] earlier,
   input  logic [rwhf_pkg::STAMP_W-1:0] later,
   input  logic [rwhf_pkg::DELTA_W-1:0] expected_delta,
   output logic                         is_break
);

   logic [rwhf_pkg::STAMP_W-1:0] offset;

   always_comb begin
      offset = later - earlier - expected_delta + rwhf_pkg::STAMP_W'(1);
      is_break = (offset > rwhf_pkg::STAMP_W'(2));
   end

endmodule

### rtl/rwhf_snapshot.sv
// Snapshot tracker: first/previous stamp, position, break count and break log.
// Classifies the adjacent gap and, on the last word, the wrap gap.
// Depends on rwhf_pkg and rwhf_gap_check.
module rwhf_snapshot #(
   parameter int MAX_RING = rwhf_pkg::MAX_RING_DEFAULT,
   parameter int LOG_SLOTS = rwhf_pkg::LOG_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          word_valid,
   input  logic                          commit,
   input  logic [rwhf_pkg::STAMP_W-1:0]  stamp,
   input  logic [rwhf_pkg::DELTA_W-1:0]  expected_delta,
   input  logic [rwhf_pkg::LENGTH_W-1:0] ring_length,
   output logic                          last_word,
   output rwhf_pkg::result_type          result
);

   localparam int POS_W = (MAX_RING > 2) ? $clog2(MAX_RING) : 1;
   localparam int CMP_W = (POS_W + 1 > rwhf_pkg::LENGTH_W + 1) ? POS_W + 1
                                                               : rwhf_pkg::LENGTH_W + 1;
   localparam int NSLOT = (LOG_SLOTS < rwhf_pkg::OUT_SLOTS) ? LOG_SLOTS
                                                            : rwhf_pkg::OUT_SLOTS;
   localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_RING);
   localparam logic [CMP_W-1:0] MIN_LEN = CMP_W'(rwhf_pkg::MIN_RING);

   logic [rwhf_pkg::STAMP_W-1:0] first_ff, first_in;
   logic [rwhf_pkg::STAMP_W-1:0] prev_ff, prev_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [rwhf_pkg::COUNT_W-1:0] count_ff, count_in;
   rwhf_pkg::index_type          latest_ff, latest_in;
   rwhf_pkg::index_type          log_ff [NSLOT];
   rwhf_pkg::index_type          log_in [NSLOT];

   logic [CMP_W-1:0]             len;
   logic [CMP_W-1:0]             ring_ext;
   logic                         first_word;
   logic                         adj_break, wrap_break;
   logic                         b0, b1;
   rwhf_pkg::index_type          idx0, idx1;
   logic [rwhf_pkg::COUNT_W-1:0] cnt1, cnt2;

   rwhf_gap_check u_adj_gap (
      .earlier        (prev_ff),
      .later          (stamp),
      .expected_delta (expected_delta),
      .is_break       (adj_break)
   );

   rwhf_gap_check u_wrap_gap (
      .earlier        (stamp),
      .later          (first_ff),
      .expected_delta (expected_delta),
      .is_break       (wrap_break)
   );

   always_comb begin
      ring_ext = CMP_W'(ring_length);
      if (ring_ext < MIN_LEN) begin
         len = MIN_LEN;
      end else if (ring_ext > MAX_LEN) begin
         len = MAX_LEN;
      end else begin
         len = ring_ext;
      end
      first_word = (pos_ff == '0);
      last_word = word_valid && !first_word && (CMP_W'(pos_ff) + CMP_W'(1) >= len);

      // break charged to the earlier word of each pair
      b0 = !first_word && adj_break;
      b1 = last_word && wrap_break;
      idx0 = rwhf_pkg::INDEX_W'(pos_ff - POS_W'(1));
      idx1 = rwhf_pkg::INDEX_W'(pos_ff);
      cnt1 = count_ff + rwhf_pkg::COUNT_W'(b0);
      cnt2 = cnt1 + rwhf_pkg::COUNT_W'(b1);

      for (int k = 0; k < NSLOT; k++) begin
         if (b0 && count_ff == rwhf_pkg::COUNT_W'(k)) begin
            log_in[k] = idx0;
         end else if (b1 && cnt1 == rwhf_pkg::COUNT_W'(k)) begin
            log_in[k] = idx1;
         end else begin
            log_in[k] = log_ff[k];
         end
      end

      if (b1) begin
         latest_in = idx1;
      end else if (b0) begin
         latest_in = idx0;
      end else begin
         latest_in = latest_ff;
      end

      first_in = first_word ? stamp : first_ff;
      prev_in = stamp;
      count_in = cnt2;
      pos_in = pos_ff + POS_W'(1);

      result.head_found = (cnt2 == rwhf_pkg::COUNT_W'(1));
      result.head_index = result.head_found ? latest_in : '0;
      result.break_count = cnt2;

      // unlogged slots (beyond the log depth) read as zero
      for (int k = 0; k < rwhf_pkg::OUT_SLOTS; k++) begin
         result.break_index[k] = '0;
      end
      for (int k = 0; k < NSLOT; k++) begin
         result.break_index[k] = log_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         prev_ff <= '0;
         pos_ff <= '0;
         count_ff <= '0;
         latest_ff <= '0;
         for (int k = 0; k < NSLOT; k++) begin
            log_ff[k] <= '0;
         end
      end else if (commit) begin
         first_ff <= first_in;
         prev_ff <= prev_in;
         if (last_word) begin
            pos_ff <= '0;
            count_ff <= '0;
            latest_ff <= '0;
            for (int k = 0; k < NSLOT; k++) begin
               log_ff[k] <= '0;
            end
         end else begin
            pos_ff <= pos_in;
            count_ff <= first_word ? count_ff : count_in;
            latest_ff <= latest_in;
            for (int k = 0; k < NSLOT; k++) begin
               log_ff[k] <= log_in[k];
            end
         end
      end
   end

endmodule

### rtl/ring_write_head_finder.sv
// Ring write head finder, top level: input register, snapshot tracker, result register.
// A snapshot's result is loaded into the result register as its last word leaves the input register.
// Throughput: one word per cycle while words do not stall; the result register lets the next snapshot stream on.
// Words stall only while a finished result is held and the in-flight word is a last word.
// Reset (synchronous) empties both registers, starts a new snapshot and loads the
// register defaults: expected delta 10000, ring length 2048.
module ring_write_head_finder #(
   parameter int MAX_RING = rwhf_pkg::MAX_RING_DEFAULT,
   parameter int LOG_SLOTS = rwhf_pkg::LOG_SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rwhf_pkg::STAMP_W-1:0]     req_stamp_low,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_head_found,
   output logic [rwhf_pkg::INDEX_W-1:0]     rsp_head_index,
   output logic [rwhf_pkg::COUNT_W-1:0]     rsp_break_count,
   output logic [rwhf_pkg::INDEX_W-1:0]     rsp_first_break_index,
   output logic [rwhf_pkg::INDEX_W-1:0]     rsp_second_break_index,
   output logic [rwhf_pkg::INDEX_W-1:0]     rsp_third_break_index,
   output logic [rwhf_pkg::INDEX_W-1:0]     rsp_fourth_break_index,
   input  logic                             csr_write_enable,
   input  logic [rwhf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rwhf_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic [rwhf_pkg::DELTA_W-1:0]  delta_ff;
   logic [rwhf_pkg::LENGTH_W-1:0] length_ff;

   logic                          in_valid_ff, in_valid_in;
   logic [rwhf_pkg::STAMP_W-1:0]  in_stamp_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   rwhf_pkg::result_type          rsp_data_ff, result;

   logic                          req_take;
   logic                          last_word;
   logic                          advance;

   rwhf_snapshot #(
      .MAX_RING  (MAX_RING),
      .LOG_SLOTS (LOG_SLOTS)
   ) u_snapshot (
      .clock          (clock),
      .reset          (reset),
      .word_valid     (in_valid_ff),
      .commit         (advance),
      .stamp          (in_stamp_ff),
      .expected_delta (delta_ff),
      .ring_length    (length_ff),
      .last_word      (last_word),
      .result         (result)
   );

   always_comb begin
      // a last word waits only when the result register cannot take its result
      advance = in_valid_ff && (!last_word || !rsp_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !advance;
      req_take = req_valid && !req_stall;
      in_valid_in = req_take || (in_valid_ff && !advance);
      rsp_valid_in = (advance && last_word) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         delta_ff <= rwhf_pkg::DELTA_RESET;
         length_ff <= rwhf_pkg::LENGTH_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               rwhf_pkg::CSR_EXPECTED_DELTA: begin
                  delta_ff <= rwhf_pkg::DELTA_W'(csr_write_data);
               end
               rwhf_pkg::CSR_RING_LENGTH: begin
                  length_ff <= rwhf_pkg::LENGTH_W'(csr_write_data);
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_stamp_ff <= req_stamp_low;
      end
      if (advance && last_word) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_head_found = rsp_data_ff.head_found;
   assign rsp_head_index = rsp_data_ff.head_index;
   assign rsp_break_count = rsp_data_ff.break_count;
   assign rsp_first_break_index = rsp_data_ff.break_index[0];
   assign rsp_second_break_index = rsp_data_ff.break_index[1];
   assign rsp_third_break_index = rsp_data_ff.break_index[2];
   assign rsp_fourth_break_index = rsp_data_ff.break_index[3];

endmodule

### rtl/rwhf_checker.sv
// Port-level checker for the ring write head finder, bound to the top level.
// Depends on rwhf_pkg.
module rwhf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_head_found,
   input logic [rwhf_pkg::INDEX_W-1:0] rsp_head_index,
   input logic [rwhf_pkg::COUNT_W-1:0] rsp_break_count,
   input logic [rwhf_pkg::INDEX_W-1:0] rsp_first_break_index,
   input logic [rwhf_pkg::INDEX_W-1:0] rsp_second_break_index
);

   // a held result stays put until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_break_count)
         && $stable(rsp_head_index) && $stable(rsp_first_break_index))
      else $error("result changed while stalled");

   a_head_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_head_found == (rsp_break_count == rwhf_pkg::COUNT_W'(1)))
      else $error("head_found disagrees with break count");

   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_found |-> rsp_head_index == '0)
      else $error("head index nonzero without a head");

   a_head_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_head_found |-> rsp_head_index == rsp_first_break_index
         && rsp_second_break_index == '0)
      else $error("single break not logged as first");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ring_write_head_finder rwhf_checker u_rwhf_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_head_found         (rsp_head_found),
   .rsp_head_index         (rsp_head_index),
   .rsp_break_count        (rsp_break_count),
   .rsp_first_break_index  (rsp_first_break_index),
   .rsp_second_break_index (rsp_second_break_index)
);

### tb/sv/ring_head_checker.sv
// Checker for the ring write head finder: follows register writes, predicts one
// report per closed ring from the stamp transfers and compares each report field
// by field. Depends on rwhf_pkg.
module ring_head_checker
   import rwhf_pkg::*;
#(
   parameter int MAX_RING = MAX_RING_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [STAMP_W-1:0]     req_stamp_low,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_head_found,
   input  logic [INDEX_W-1:0]     rsp_head_index,
   input  logic [COUNT_W-1:0]     rsp_break_count,
   input  logic [INDEX_W-1:0]     rsp_first_break_index,
   input  logic [INDEX_W-1:0]     rsp_second_break_index,
   input  logic [INDEX_W-1:0]     rsp_third_break_index,
   input  logic [INDEX_W-1:0]     rsp_fourth_break_index,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     fail_count,
   output int                     pending_reports,
   output int                     reports_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DELTA_W-1:0]  cfg_delta;
   logic [LENGTH_W-1:0] cfg_length;

   logic [STAMP_W-1:0]  ring_first;
   logic [STAMP_W-1:0]  ring_prev;
   int unsigned         ring_pos;
   logic [COUNT_W-1:0]  break_total;
   index_type           last_break_at;
   index_type           break_slots [OUT_SLOTS];

   result_type          expected_reports [$];
   result_type          fresh;
   result_type          seen;
   result_type          want;

   string slot_name [OUT_SLOTS] = '{"first_break_index", "second_break_index",
                                    "third_break_index", "fourth_break_index"};

   function automatic void clear_ring();
      ring_pos = 0;
      break_total = '0;
      last_break_at = '0;
      foreach (break_slots[k]) break_slots[k] = '0;
   endfunction

   // a gap is a step when it sits within one tick of the delta, mod 2^32
   function automatic void tally_gap(input logic [STAMP_W-1:0] gap, input int unsigned at);
      logic [STAMP_W-1:0] offset;
      offset = gap - cfg_delta + 32'd1;
      if (offset > 32'd2) begin
         if (break_total < OUT_SLOTS) break_slots[break_total] = at[INDEX_W-1:0];
         break_total++;
         last_break_at = at[INDEX_W-1:0];
      end
   endfunction

   function automatic bit absorb_stamp(input logic [STAMP_W-1:0] stamp,
                                       output result_type report);
      int unsigned span;
      int k;
      span = cfg_length;
      if (span < MIN_RING) span = MIN_RING;
      if (span > MAX_RING) span = MAX_RING;
      if (ring_pos == 0) begin
         ring_first = stamp;
         ring_prev = stamp;
         ring_pos = 1;
         return 1'b0;
      end
      tally_gap(stamp - ring_prev, ring_pos - 1);
      ring_prev = stamp;
      // length is checked on every word, so a shortened ring closes at once
      if (ring_pos + 1 < span) begin
         ring_pos++;
         return 1'b0;
      end
      tally_gap(ring_first - stamp, ring_pos);
      report.head_found = (break_total == 1);
      report.head_index = (break_total == 1) ? last_break_at : '0;
      report.break_count = break_total;
      for (k = 0; k < OUT_SLOTS; k++)
         report.break_index[k] = (k < break_total) ? break_slots[k] : '0;
      clear_ring();
      return 1'b1;
   endfunction

   function automatic void flag_field(input string field, input logic [31:0] expected_value,
                                      input logic [31:0] actual_value);
      if (expected_value !== actual_value) begin
         if (fail_count < 10)
            $display("%t: report %0d, %s: expected %0d, got %0d", $realtime,
                     reports_checked, field, expected_value, actual_value);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_delta = DELTA_RESET;
         cfg_length = LENGTH_RESET;
         ring_first = '0;
         ring_prev = '0;
         clear_ring();
         expected_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.head_found = rsp_head_found;
            seen.head_index = rsp_head_index;
            seen.break_count = rsp_break_count;
            seen.break_index[0] = rsp_first_break_index;
            seen.break_index[1] = rsp_second_break_index;
            seen.break_index[2] = rsp_third_break_index;
            seen.break_index[3] = rsp_fourth_break_index;
            if (expected_reports.size() == 0) begin
               if (fail_count < 10)
                  $display("%t: report transfer with no report predicted", $realtime);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               flag_field("head_found", want.head_found, seen.head_found);
               flag_field("head_index", want.head_index, seen.head_index);
               flag_field("break_count", want.break_count, seen.break_count);
               foreach (slot_name[k])
                  flag_field(slot_name[k], want.break_index[k], seen.break_index[k]);
               reports_checked++;
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_EXPECTED_DELTA: cfg_delta = csr_write_data[DELTA_W-1:0];
               CSR_RING_LENGTH: cfg_length = csr_write_data[LENGTH_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (absorb_stamp(req_stamp_low, fresh)) expected_reports.push_back(fresh);
         end
      end
      pending_reports = expected_reports.size();
   end

endmodule

### tb/sv/testbench.sv
// Top of the ring write head finder testbench: clock, reset, register writes,
// stamp stimulus and report-side stalls; ring_head_checker does the checking.
// Depends on rwhf_pkg, ring_write_head_finder and ring_head_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rwhf_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [STAMP_W-1:0]     req_stamp_low = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_head_found;
   logic [INDEX_W-1:0]     rsp_head_index;
   logic [COUNT_W-1:0]     rsp_break_count;
   logic [INDEX_W-1:0]     rsp_first_break_index;
   logic [INDEX_W-1:0]     rsp_second_break_index;
   logic [INDEX_W-1:0]     rsp_third_break_index;
   logic [INDEX_W-1:0]     rsp_fourth_break_index;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   int mismatches;
   int reports_due;
   int reports_seen;

   int                 items_sent = 0;
   int                 settings_applied = 0;
   int                 cur_span = 2048;
   logic [DELTA_W-1:0] cur_delta = 32'd10000;
   bit                 send_burst = 1'b0;
   bit                 hold_request = 1'b0;

   ring_write_head_finder i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_stamp_low          (req_stamp_low),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_head_found         (rsp_head_found),
      .rsp_head_index         (rsp_head_index),
      .rsp_break_count        (rsp_break_count),
      .rsp_first_break_index  (rsp_first_break_index),
      .rsp_second_break_index (rsp_second_break_index),
      .rsp_third_break_index  (rsp_third_break_index),
      .rsp_fourth_break_index (rsp_fourth_break_index),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   ring_head_checker i_head_check (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_stamp_low          (req_stamp_low),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_head_found         (rsp_head_found),
      .rsp_head_index         (rsp_head_index),
      .rsp_break_count        (rsp_break_count),
      .rsp_first_break_index  (rsp_first_break_index),
      .rsp_second_break_index (rsp_second_break_index),
      .rsp_third_break_index  (rsp_third_break_index),
      .rsp_fourth_break_index (rsp_fourth_break_index),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .fail_count             (mismatches),
      .pending_reports        (reports_due),
      .reports_checked        (reports_seen)
   );

   always #10 clock = ~clock;

   // entered and left at a falling edge
   task automatic push_stamp(input logic [STAMP_W-1:0] stamp);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (send_burst || roll < 60) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_stamp_low <= stamp;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // wait for every predicted report, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_ring(input logic [DELTA_W-1:0] delta,
                               input logic [CSR_DATA_W-1:0] length_word);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_EXPECTED_DELTA;
      csr_write_data <= delta;
      @(negedge clock);
      csr_index <= CSR_RING_LENGTH;
      csr_write_data <= length_word;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_delta = delta;
      cur_span = length_word[LENGTH_W-1:0];
      if (cur_span < MIN_RING) cur_span = MIN_RING;
      if (cur_span > MAX_RING_DEFAULT) cur_span = MAX_RING_DEFAULT;
      settings_applied++;
   endtask

   // writes the length only, so the delta keeps its current value
   task automatic program_length(input logic [CSR_DATA_W-1:0] length_word);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_RING_LENGTH;
      csr_write_data <= length_word;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_span = length_word[LENGTH_W-1:0];
      if (cur_span < MIN_RING) cur_span = MIN_RING;
      if (cur_span > MAX_RING_DEFAULT) cur_span = MAX_RING_DEFAULT;
      settings_applied++;
   endtask

   // Ring whose newest record sits at head: walks forward from the oldest one with
   // steps of delta +-1, so the wrap from head to head+1 is the natural break.
   // upset_pct of the steps are spoiled by a random jump or a step off by two.
   task automatic send_ring(input int span, input logic [DELTA_W-1:0] delta,
                            input int head, input int upset_pct);
      logic [STAMP_W-1:0] stamps [];
      logic [STAMP_W-1:0] value;
      int slot;
      stamps = new[span];
      value = $urandom;
      slot = (head + 1) % span;
      repeat (span) begin
         stamps[slot] = value;
         if ($urandom_range(1, 100) <= upset_pct) begin
            if ($urandom_range(0, 1)) value = $urandom;
            else value = value + delta + ($urandom_range(0, 1) ? 32'd2 : -32'd2);
         end else begin
            value = value + delta + $urandom_range(0, 2) - 32'd1;
         end
         slot = (slot + 1) % span;
      end
      foreach (stamps[i]) push_stamp(stamps[i]);
   endtask

   task automatic run_phase(input bit squeeze);
      logic [DELTA_W-1:0]    delta;
      logic [CSR_DATA_W-1:0] length_word;
      logic [STAMP_W-1:0]    fill;
      int roll;
      int rings;
      int noise;
      case ($urandom_range(0, 7))
         0: delta = 32'd0;
         1: delta = 32'd1;
         2: delta = 32'hFFFF_FFFF;
         3: delta = 32'd10000;
         4: delta = 32'hFFFF_FFFE;
         default: delta = $urandom;
      endcase
      length_word = $urandom;   // bits above the length field are ignored
      roll = $urandom_range(0, 99);
      if (squeeze) length_word[LENGTH_W-1:0] = $urandom_range(2, 3);
      else if (roll < 70) length_word[LENGTH_W-1:0] = $urandom_range(2, 12);
      else if (roll < 85) length_word[LENGTH_W-1:0] = $urandom_range(13, 40);
      else if (roll < 92) length_word[LENGTH_W-1:0] = $urandom_range(0, 1);
      else length_word[LENGTH_W-1:0] = $urandom_range(41, 200);
      program_ring(delta, length_word);
      send_burst = squeeze || ($urandom_range(0, 3) == 0);
      rings = squeeze ? 60 : $urandom_range(1, 1 + 80 / cur_span);
      // receiver holds off while short rings keep coming, so the block backs up
      if (squeeze) hold_request = 1'b1;
      repeat (rings) begin
         if ($urandom_range(0, 4) != 0) begin
            send_ring(cur_span, cur_delta, $urandom_range(0, cur_span - 1),
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
         end else begin
            noise = $urandom_range(0, 2);
            fill = $urandom;
            repeat (cur_span) begin
               case (noise)
                  0: push_stamp($urandom);
                  1: push_stamp(fill);
                  default: push_stamp($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
               endcase
            end
         end
      end
      // sometimes leave a ring open so the next register write lands mid-ring
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, cur_span - 1)) push_stamp($urandom);
      settle();
   endtask

   initial begin : stimulus
      int base;
      int phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // delta default straight out of reset, on a short ring
      program_length(32'd5);
      send_ring(cur_span, cur_delta, $urandom_range(0, cur_span - 1), 0);
      settle();

      // two-word ring at both ends of the stamp range; lengths below two act as two
      program_ring(32'd0, 32'd1);
      push_stamp(32'h0000_0000);
      push_stamp(32'hFFFF_FFFF);
      settle();
      program_ring(32'hFFFF_FFFF, 32'd0);
      push_stamp(32'hFFFF_FFFF);
      push_stamp(32'h0000_0000);
      settle();
      // more breaks than log slots
      program_ring(32'd5, 32'd6);
      repeat (6) push_stamp(32'h1234_5678);
      settle();
      // ring shortened after three words: the next word closes it
      program_ring(32'd3, 32'd8);
      push_stamp(32'd100);
      push_stamp(32'd103);
      push_stamp(32'd106);
      settle();
      program_ring(32'd4, 32'd3);
      push_stamp(32'd109);
      settle();
      program_ring(32'd10000, 32'd4);
      send_ring(cur_span, cur_delta, 1, 0);
      settle();
      // steps off by two count as breaks
      program_ring(32'd7, 32'd3);
      push_stamp(32'd0);
      push_stamp(32'd9);
      push_stamp(32'd14);
      settle();

      base = items_sent;
      phase = 0;
      while (items_sent - base < 1100 || phase <= 4) begin
         run_phase(phase == 4);
         phase++;
      end
      repeat (8) @(negedge clock);

      $display("covered %0d stamp words over %0d register settings (%0d random phases)",
               items_sent, settings_applied, phase);
      $display("compared %0d reports, %0d mismatches", reports_seen, mismatches);
      if (mismatches == 0 && reports_due == 0) begin
         $display("PASS ring_write_head_finder");
      end else begin
         $display("FAIL ring_write_head_finder");
      end
      $finish;
   end

   initial begin : report_sink
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (free_left > 0) begin
               free_left--;
            end else begin
               free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 5);
               case ($urandom_range(0, 9))
                  0: stall_left = $urandom_range(8, 40);
                  1, 2, 3, 4: stall_left = $urandom_range(1, 3);
                  default: stall_left = 0;
               endcase
            end
         end
      end
   end

   initial begin : watchdog
      #30_000_000;
      $display("run timed out with %0d reports outstanding", reports_due);
      $display("FAIL ring_write_head_finder");
      $finish;
   end

endmodule
